[sv/bctd_pkg.sv]
// bctd_pkg: format codes and texel arithmetic for the bc texture block decoder
`default_nettype none
package bctd_pkg;

  localparam int unsigned TexelW = 4;
  localparam int unsigned ChanW  = 8;

  localparam logic [1:0] FMT_BC1 = 2'd0;
  localparam logic [1:0] FMT_BC2 = 2'd1;
  localparam logic [1:0] FMT_BC3 = 2'd2;

  // 5 and 6 bit channels to 8 bits by bit replication
  function automatic logic [7:0] widen5(input logic [4:0] v);
    return {v, v[4:2]};
  endfunction

  function automatic logic [7:0] widen6(input logic [5:0] v);
    return {v, v[5:4]};
  endfunction

  // x / 3 for x <= 765 by reciprocal multiply
  function automatic logic [7:0] div3(input logic [9:0] x);
    logic [19:0] p;
    p = 20'(x) * 20'd683;
    return p[18:11];
  endfunction

  // x / 5 for x <= 1275
  function automatic logic [7:0] div5(input logic [10:0] x);
    logic [20:0] p;
    p = 21'(x) * 21'd1639;
    return p[20:13];
  endfunction

  // x / 7 for x <= 1785
  function automatic logic [7:0] div7(input logic [10:0] x);
    logic [21:0] p;
    p = 22'(x) * 22'd2341;
    return p[21:14];
  endfunction

  // one color channel of palette entry k
  function automatic logic [7:0] color_chan(input logic [7:0] c0, input logic [7:0] c1,
                                            input logic [1:0] k, input logic four);
    logic [9:0] a;
    logic [9:0] b;
    logic [8:0] s;
    a = 10'(c0);
    b = 10'(c1);
    s = 9'(c0) + 9'(c1);
    case (k)
      2'd0:    return c0;
      2'd1:    return c1;
      2'd2:    return four ? div3((a << 1) + b) : s[8:1];
      default: return four ? div3(a + (b << 1)) : 8'd0;
    endcase
  endfunction

  // interpolated alpha palette entry j
  function automatic logic [7:0] alpha_entry(input logic [7:0] a0, input logic [7:0] a1,
                                             input logic [2:0] j);
    logic [10:0] x;
    logic [10:0] y;
    x = 11'(a0);
    y = 11'(a1);
    if (j == 3'd0) begin
      return a0;
    end else if (j == 3'd1) begin
      return a1;
    end else if (a0 > a1) begin
      case (j)
        3'd2:    return div7(x * 11'd6 + y);
        3'd3:    return div7(x * 11'd5 + y * 11'd2);
        3'd4:    return div7(x * 11'd4 + y * 11'd3);
        3'd5:    return div7(x * 11'd3 + y * 11'd4);
        3'd6:    return div7(x * 11'd2 + y * 11'd5);
        default: return div7(x + y * 11'd6);
      endcase
    end else begin
      case (j)
        3'd2:    return div5(x * 11'd4 + y);
        3'd3:    return div5(x * 11'd3 + y * 11'd2);
        3'd4:    return div5(x * 11'd2 + y * 11'd3);
        3'd5:    return div5(x + y * 11'd4);
        3'd6:    return 8'd0;
        default: return 8'd255;
      endcase
    end
  endfunction

endpackage
`default_nettype wire

[sv/bc_texture_block_decoder.sv]
// bc_texture_block_decoder: bc1/bc2/bc3 4x4 block to sixteen rgba texels
// the first texel passes from the block register through the texel decode path into the output register
// throughput: one texel per cycle while the output is not stalled, set by the single
//   texel decode path between the block register and the output register
// the next block is taken while the sixteenth texel moves to the output register
// reset: asynchronous active low; clears valids, texel counter and format (bc1)
`default_nettype none
module bc_texture_block_decoder (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        cfg_we_i,
  input  wire logic [1:0]                  cfg_wdata_i,
  input  wire logic                        in_valid_i,
  output logic                             in_stall_o,
  input  wire logic [63:0]                 color_block_i,
  input  wire logic [63:0]                 alpha_block_i,
  output logic                             out_valid_o,
  input  wire logic                        out_stall_i,
  output logic [bctd_pkg::TexelW-1:0]      texel_index_o,
  output logic [bctd_pkg::ChanW-1:0]       red_o,
  output logic [bctd_pkg::ChanW-1:0]       green_o,
  output logic [bctd_pkg::ChanW-1:0]       blue_o,
  output logic [bctd_pkg::ChanW-1:0]       alpha_o,
  output logic                             last_o
);
  import bctd_pkg::*;

  logic [1:0]        fmt_q;
  logic              blk_vld_q;
  logic [63:0]       color_q;
  logic [63:0]       alpha_q;
  logic [TexelW-1:0] cnt_q;

  logic              out_vld_q;
  logic [TexelW-1:0] idx_q;
  logic [ChanW-1:0]  red_q, green_q, blue_q, alpha_out_q;
  logic              last_q;

  logic              out_free;
  logic              advance;
  logic              in_xfer;
  logic              blk_done;

  logic [15:0]       e0, e1;
  logic              four;
  logic [31:0]       cidx;
  logic [1:0]        k;
  logic [3:0]        nib;
  logic [47:0]       aidx;
  logic [5:0]        apos;
  logic [2:0]        aj;
  logic [ChanW-1:0]  r_d, g_d, b_d, a_d;

  assign out_free  = !out_vld_q || !out_stall_i;
  assign advance   = blk_vld_q && out_free;
  assign blk_done  = advance && (cnt_q == TexelW'(15));
  assign in_stall_o = blk_vld_q && !blk_done;
  assign in_xfer   = in_valid_i && !in_stall_o;

  // texel decode
  assign e0   = color_q[15:0];
  assign e1   = color_q[31:16];
  assign four = (e0 > e1) || (fmt_q != FMT_BC1);
  assign cidx = color_q[63:32];
  assign k    = cidx[{cnt_q, 1'b0} +: 2];
  assign nib  = alpha_q[{cnt_q, 2'b00} +: 4];
  assign aidx = alpha_q[63:16];
  assign apos = {2'b00, cnt_q} + {1'b0, cnt_q, 1'b0};
  assign aj   = aidx[apos +: 3];

  assign r_d = color_chan(widen5(e0[15:11]), widen5(e1[15:11]), k, four);
  assign g_d = color_chan(widen6(e0[10:5]), widen6(e1[10:5]), k, four);
  assign b_d = color_chan(widen5(e0[4:0]), widen5(e1[4:0]), k, four);

  always_comb begin
    unique case (fmt_q)
      FMT_BC1: a_d = (k == 2'd3 && !four) ? 8'd0 : 8'd255;
      FMT_BC2: a_d = {nib, nib};
      default: a_d = alpha_entry(alpha_q[7:0], alpha_q[15:8], aj);
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fmt_q     <= FMT_BC1;
      blk_vld_q <= 1'b0;
      cnt_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        fmt_q <= cfg_wdata_i;
      end
      if (in_xfer) begin
        blk_vld_q <= 1'b1;
        cnt_q     <= '0;
      end else if (advance) begin
        cnt_q <= cnt_q + TexelW'(1);
        if (blk_done) begin
          blk_vld_q <= 1'b0;
        end
      end
      if (out_free) begin
        out_vld_q <= blk_vld_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      color_q <= color_block_i;
      alpha_q <= alpha_block_i;
    end
    if (advance) begin
      idx_q       <= cnt_q;
      red_q       <= r_d;
      green_q     <= g_d;
      blue_q      <= b_d;
      alpha_out_q <= a_d;
      last_q      <= (cnt_q == TexelW'(15));
    end
  end

  assign out_valid_o   = out_vld_q;
  assign texel_index_o = idx_q;
  assign red_o         = red_q;
  assign green_o       = green_q;
  assign blue_o        = blue_q;
  assign alpha_o       = alpha_out_q;
  assign last_o        = last_q;

  // a new block starts at texel zero
  a_start_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> cnt_q == '0)
    else $error("texel counter not cleared on block transfer");

  // the block register only frees up on its last texel
  a_free_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (blk_vld_q && !in_stall_o) |-> cnt_q == TexelW'(15))
    else $error("block register released early");

  // texels of one block follow in order
  a_texel_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_stall_i && !last_o) ##1 out_valid_o
      |-> texel_index_o == TexelW'($past(texel_index_o) + TexelW'(1)))
    else $error("texel index out of order");

  // last marks texel fifteen
  a_last_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (last_o == (texel_index_o == TexelW'(15))))
    else $error("last flag does not match texel index");

endmodule
`default_nettype wire

[bench/bctd_checker.sv]
// bctd_checker: texel predictor and scoreboard for the bc texture block decoder
`timescale 1ns / 1ps
module bctd_checker (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [1:0]                  cfg_wdata_i,
  input  logic                        in_valid_i,
  input  logic                        in_stall_i,
  input  logic [63:0]                 color_block_i,
  input  logic [63:0]                 alpha_block_i,
  input  logic                        out_valid_i,
  input  logic                        out_stall_i,
  input  logic [bctd_pkg::TexelW-1:0] texel_index_i,
  input  logic [bctd_pkg::ChanW-1:0]  red_i,
  input  logic [bctd_pkg::ChanW-1:0]  green_i,
  input  logic [bctd_pkg::ChanW-1:0]  blue_i,
  input  logic [bctd_pkg::ChanW-1:0]  alpha_i,
  input  logic                        last_i,
  output int                          fail_count_o,
  output int                          pending_o,
  output int                          checked_o
);
  import bctd_pkg::*;

  typedef struct packed {
    logic [TexelW-1:0] idx;
    logic [ChanW-1:0]  red;
    logic [ChanW-1:0]  green;
    logic [ChanW-1:0]  blue;
    logic [ChanW-1:0]  alpha;
    logic              last;
  } texel_t;

  texel_t     texel_q[$];
  logic [1:0] fmt_q;

  // replicate the top bits of a 5 or 6 bit channel into the low bits
  function automatic int expand(input int v, input int bits);
    return (bits == 5) ? (v * 33) >> 2 : (v * 65) >> 4;
  endfunction

  function automatic void predict_block(input logic [1:0] fmt, input logic [63:0] cb,
                                        input logic [63:0] ab);
    int     ep0;
    int     ep1;
    int     ep;
    int     col[4][3];
    int     col_a[4];
    int     apal[8];
    int     k;
    logic   four;
    texel_t t;
    ep0 = int'(cb[15:0]);
    ep1 = int'(cb[31:16]);
    for (int m = 0; m < 2; m++) begin
      ep = (m == 0) ? ep0 : ep1;
      col[m][0] = expand((ep >> 11) & 31, 5);
      col[m][1] = expand((ep >> 5) & 63, 6);
      col[m][2] = expand(ep & 31, 5);
    end
    // bc2 and bc3 never use the punch-through palette
    four = (ep0 > ep1) || (fmt != FMT_BC1);
    for (int ch = 0; ch < 3; ch++) begin
      if (four) begin
        col[2][ch] = (2 * col[0][ch] + col[1][ch]) / 3;
        col[3][ch] = (col[0][ch] + 2 * col[1][ch]) / 3;
      end else begin
        col[2][ch] = (col[0][ch] + col[1][ch]) / 2;
        col[3][ch] = 0;
      end
    end
    col_a[0] = 255;
    col_a[1] = 255;
    col_a[2] = 255;
    col_a[3] = four ? 255 : 0;
    apal[0] = int'(ab[7:0]);
    apal[1] = int'(ab[15:8]);
    if (apal[0] > apal[1]) begin
      for (int s = 1; s <= 6; s++) apal[s + 1] = ((7 - s) * apal[0] + s * apal[1]) / 7;
    end else begin
      for (int s = 1; s <= 4; s++) apal[s + 1] = ((5 - s) * apal[0] + s * apal[1]) / 5;
      apal[6] = 0;
      apal[7] = 255;
    end
    for (int p = 0; p < 16; p++) begin
      k       = int'(cb[32 + 2 * p +: 2]);
      t.idx   = TexelW'(p);
      t.red   = ChanW'(col[k][0]);
      t.green = ChanW'(col[k][1]);
      t.blue  = ChanW'(col[k][2]);
      case (fmt)
        FMT_BC1: t.alpha = ChanW'(col_a[k]);
        FMT_BC2: t.alpha = ChanW'(int'(ab[4 * p +: 4]) * 17);
        default: t.alpha = ChanW'(apal[ab[16 + 3 * p +: 3]]);
      endcase
      t.last = (p == 15);
      texel_q.push_back(t);
    end
  endfunction

  function automatic void note_failure(input string msg);
    fail_count_o++;
    if (fail_count_o <= 10) $display("%t: %s", $realtime, msg);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    texel_t got;
    texel_t want;
    if (!rst_ni) begin
      texel_q.delete();
      fmt_q        = FMT_BC1;
      fail_count_o = 0;
      pending_o    = 0;
      checked_o    = 0;
    end else begin
      // a texel leaving now can never belong to a block arriving at this edge
      if (out_valid_i && !out_stall_i) begin
        got = '{texel_index_i, red_i, green_i, blue_i, alpha_i, last_i};
        if (texel_q.size() == 0) begin
          note_failure($sformatf("texel %0d transferred with none pending", texel_index_i));
        end else begin
          want = texel_q.pop_front();
          checked_o++;
          if (got !== want) begin
            note_failure($sformatf({"texel mismatch: expected idx %0d rgba %02x %02x %02x %02x",
                                    " last %0b, got idx %0d rgba %02x %02x %02x %02x last %0b"},
                                   want.idx, want.red, want.green, want.blue, want.alpha,
                                   want.last, got.idx, got.red, got.green, got.blue,
                                   got.alpha, got.last));
          end
        end
      end
      if (in_valid_i && !in_stall_i) predict_block(fmt_q, color_block_i, alpha_block_i);
      if (cfg_we_i) fmt_q = cfg_wdata_i;
      pending_o = texel_q.size();
    end
  end

endmodule

[bench/tb_top.sv]
// tb_top: stimulus and verdict for the bc texture block decoder
`timescale 1ns / 1ps
module tb_top;
  import bctd_pkg::*;

  localparam logic [1:0] FmtSpare   = 2'd3;
  localparam int         CycleLimit = 400000;
  localparam int         PhaseLen   = 47;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        cfg_we_i      = 1'b0;
  logic [1:0]  cfg_wdata_i   = '0;
  logic        in_valid_i    = 1'b0;
  logic [63:0] color_block_i = '0;
  logic [63:0] alpha_block_i = '0;
  logic        out_stall_i   = 1'b0;
  logic        quiet         = 1'b0;

  logic                in_stall_o;
  logic                out_valid_o;
  logic [TexelW-1:0]   texel_index_o;
  logic [ChanW-1:0]    red_o;
  logic [ChanW-1:0]    green_o;
  logic [ChanW-1:0]    blue_o;
  logic [ChanW-1:0]    alpha_o;
  logic                last_o;

  int fail_count;
  int pending;
  int checked;
  int cycle_count  = 0;
  int blocks_sent  = 0;
  int directed_cnt = 0;

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  always @(posedge clk_i) cycle_count <= cycle_count + 1;

  initial begin
    wait (cycle_count >= CycleLimit);
    $display("timeout after %0d cycles, %0d texels still pending", cycle_count, pending);
    $display("Simulation FAILED");
    $finish;
  end

  // texel receiver backpressure
  always @(negedge clk_i) out_stall_i <= !quiet && ($urandom_range(99) < 28);

  bc_texture_block_decoder i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .color_block_i (color_block_i),
    .alpha_block_i (alpha_block_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .texel_index_o (texel_index_o),
    .red_o         (red_o),
    .green_o       (green_o),
    .blue_o        (blue_o),
    .alpha_o       (alpha_o),
    .last_o        (last_o)
  );

  bctd_checker i_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_valid_i    (in_valid_i),
    .in_stall_i    (in_stall_o),
    .color_block_i (color_block_i),
    .alpha_block_i (alpha_block_i),
    .out_valid_i   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .texel_index_i (texel_index_o),
    .red_i         (red_o),
    .green_i       (green_o),
    .blue_i        (blue_o),
    .alpha_i       (alpha_o),
    .last_i        (last_o),
    .fail_count_o  (fail_count),
    .pending_o     (pending),
    .checked_o     (checked)
  );

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // called at a falling edge, returns at the falling edge after the transfer
  task automatic push_block(input logic [63:0] cb, input logic [63:0] ab);
    while (!quiet && $urandom_range(99) < 28) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i    <= 1'b1;
    color_block_i <= cb;
    alpha_block_i <= ab;
    do @(posedge clk_i); while (in_stall_o);
    blocks_sent++;
    @(negedge clk_i);
  endtask

  task automatic finish_phase();
    in_valid_i <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic set_format(input logic [1:0] fmt);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= fmt;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  // random block, biased toward equal endpoints and palette boundaries
  task automatic make_block(output logic [63:0] cb, output logic [63:0] ab);
    cb = rand64();
    ab = rand64();
    case ($urandom_range(9))
      0: cb[31:16] = cb[15:0];
      1: cb[15:0] = $urandom_range(1) ? 16'hffff : 16'h0000;
      2: cb[31:16] = $urandom_range(1) ? 16'hffff : 16'h0000;
      3: ab[15:8] = ab[7:0];
      4: ab[15:0] = $urandom_range(1) ? 16'h00ff : 16'hff00;
      default: ;
    endcase
  endtask

  initial begin
    logic [63:0] cb;
    logic [63:0] ab;
    logic [47:0] ramp3;
    logic [31:0] quad;
    logic [1:0]  plan[10];
    for (int t = 0; t < 16; t++) ramp3[3 * t +: 3] = 3'(t % 8);
    quad = 32'he4e4e4e4;  // indices 0, 1, 2, 3 repeating
    plan = '{FMT_BC1, FMT_BC2, FMT_BC3, FmtSpare, FMT_BC3,
             FMT_BC1, FMT_BC2, FMT_BC3, FMT_BC1, FMT_BC2};

    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // bc1: four-color, punch-through and equal endpoints
    set_format(FMT_BC1);
    push_block({quad, 16'h0000, 16'hffff}, rand64());
    push_block({quad, 16'hffff, 16'h0000}, rand64());
    push_block({quad, 16'h8410, 16'h8410}, rand64());
    push_block(64'h0, 64'h0);
    push_block('1, '1);
    push_block({~quad, 16'hf81f, 16'h07e0}, rand64());
    finish_phase();

    // bc2: nibble ramp with a punch-through ordering that must stay four-color
    set_format(FMT_BC2);
    push_block({quad, 16'hffff, 16'h0000}, 64'hfedcba9876543210);
    push_block({quad, 16'h0000, 16'hffff}, 64'h0123456789abcdef);
    push_block(64'h0, 64'h0);
    push_block('1, '1);
    finish_phase();

    // bc3: eight-step, six-step and equal alpha endpoints
    set_format(FMT_BC3);
    push_block({quad, 16'h001f, 16'hf800}, {ramp3, 8'h00, 8'hff});
    push_block({quad, 16'hf800, 16'h001f}, {ramp3, 8'hff, 8'h00});
    push_block({quad, 16'h07e0, 16'h07e0}, {ramp3, 8'h80, 8'h80});
    push_block(64'h0, 64'h0);
    push_block('1, '1);
    finish_phase();

    // spare format code behaves as bc3
    set_format(FmtSpare);
    push_block({quad, 16'h0000, 16'hffff}, {ramp3, 8'h31, 8'hc7});
    push_block({quad, 16'hffff, 16'h0000}, {ramp3, 8'hc7, 8'h31});
    push_block('1, 64'h0);
    finish_phase();
    directed_cnt = blocks_sent;

    for (int ph = 0; ph < 10; ph++) begin
      set_format(plan[ph]);
      quiet <= (ph == 5);
      for (int n = 0; n < PhaseLen; n++) begin
        make_block(cb, ab);
        push_block(cb, ab);
      end
      finish_phase();
    end
    quiet <= 1'b0;
    repeat (16) @(negedge clk_i);

    $display("decoded %0d blocks (%0d directed) over bc1, bc2, bc3 and the spare format code",
             blocks_sent, directed_cnt);
    $display("%0d texels compared, %0d failures, %0d pending", checked, fail_count, pending);
    if (fail_count == 0 && pending == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
